// File: rtl/bfdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared constants and the queue entry type for the double-hash Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;
    localparam int MAX_WORDS_DEF   = 1024;
    localparam int PROBE_COUNT_DEF = 5;
    localparam int SIZE_W          = 11;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] h1;
        logic [31:0] h2;
    } bfdh_item_t;
endpackage

// File: rtl/bfdh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter front end
// Accepts transactions, splits the digest and holds them in a short queue.
// ----------------------------------------------------------------------------
module bfdh_front
    import bfdh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [63:0] key_digest,
    output logic        q_valid,
    input  logic        q_ready,
    output bfdh_item_t  q_item
);
    bfdh_item_t  mem_reg [2];
    logic        wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= '{command, key_digest[63:32], key_digest[31:0]};
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count");
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !q_valid) else $error("empty pop");
`endif
endmodule

// File: rtl/bfdh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter back end
// Computes each probe, reduces it by the filter length with a restoring
// divider, reads the store and, for inserts, writes the probe bits back.
// ----------------------------------------------------------------------------
module bfdh_back
    import bfdh_pkg::*;
#(
    parameter int MAX_WORDS   = MAX_WORDS_DEF,
    parameter int PROBE_COUNT = PROBE_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] size_in_words,
    input  logic              q_valid,
    output logic              q_ready,
    input  bfdh_item_t        q_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              all_bits_set
);
    localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PW  = $clog2(PROBE_COUNT + 1);
    localparam int MW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS + 1) : 1;
    localparam int DW  = MW + 37;
    localparam int DSTEPS = 4;

    typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_DIV, S_READ, S_WAIT, S_WRITE,
                              S_OUT} state_t;

    state_t       state_reg;
    logic [31:0]  store_mem [MAX_WORDS];
    logic [31:0]  rd_reg;
    logic [AW-1:0] clr_reg;
    logic [PW-1:0] idx_reg;
    logic [31:0]  g_reg, rem_reg;
    logic [5:0]   bit_reg;
    logic [DW-1:0] m_reg;
    logic         cmd_reg;
    logic [31:0]  h2_reg;
    logic         all_reg;
    logic         res_reg;
    logic         out_v_reg;
    logic [AW-1:0] w_addr;
    logic [4:0]   b_pos;
    logic [MW-1:0] wu;
    logic [31:0]  rem_next;
    logic [5:0]   bit_next;

    assign w_addr = rem_reg[AW+4:5];
    assign b_pos  = rem_reg[4:0];

    always_comb
    begin
        if (size_in_words == '0)
            wu = MW'(1);
        else if ({21'd0, size_in_words} > 32'(MAX_WORDS))
            wu = MW'(MAX_WORDS);
        else
            wu = MW'(size_in_words);
    end

    // Restoring remainder: each pass retires up to DSTEPS quotient bits.
    always_comb
    begin
        logic [DW-1:0] r;
        logic [5:0]  b;
        r = DW'(rem_reg);
        b = bit_reg;
        for (int k = 0; k < DSTEPS; k++)
        begin
            if (b != 6'd0)
            begin
                b = b - 6'd1;
                if (r >= (m_reg << b))
                    r = r - (m_reg << b);
            end
        end
        rem_next = r[31:0];
        bit_next = b;
    end

    assign q_ready      = (state_reg == S_IDLE);
    assign out_valid    = out_v_reg;
    assign all_bits_set = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
            out_v_reg <= 1'b0;
            all_reg   <= 1'b0;
            res_reg   <= 1'b0;
        end
        else
        begin
            if (out_v_reg && out_ready && state_reg != S_OUT)
                out_v_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == 32'(MAX_WORDS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_item.command;
                        h2_reg    <= q_item.h2;
                        g_reg     <= q_item.h1;
                        rem_reg   <= q_item.h1;
                        m_reg     <= DW'({wu, 5'd0});
                        bit_reg   <= 6'd32;
                        idx_reg   <= '0;
                        all_reg   <= 1'b1;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    bit_reg <= bit_next;
                    if (bit_next == 6'd0)
                        state_reg <= S_READ;
                end
                S_READ:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!rd_reg[b_pos])
                        all_reg <= 1'b0;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (32'(idx_reg) == 32'(PROBE_COUNT - 1))
                        state_reg <= S_OUT;
                    else
                    begin
                        idx_reg   <= idx_reg + PW'(1);
                        g_reg     <= g_reg + h2_reg;
                        rem_reg   <= g_reg + h2_reg;
                        bit_reg   <= 6'd32;
                        state_reg <= S_DIV;
                    end
                end
                S_OUT:
                begin
                    if (!out_v_reg || out_ready)
                    begin
                        out_v_reg <= 1'b1;
                        res_reg   <= all_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Reads for all probes precede writes only in result; write-after-read is
    // safe because a bit once set stays set and the outcome is taken per probe
    // before the write.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            store_mem[clr_reg] <= '0;
        else if (state_reg == S_WRITE && cmd_reg == CMD_INSERT)
            store_mem[w_addr] <= rd_reg | (32'd1 << b_pos);
        if (state_reg == S_READ)
            rd_reg <= store_mem[w_addr];
    end

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !q_ready) else $error("ready while busy");
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> DW'(rem_reg) < m_reg) else $error("remainder range");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(all_bits_set))
        else $error("result lost");
`endif
endmodule

// File: rtl/bloom_filter_double_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Each transaction passes a two-entry queue, then per probe (PROBE_COUNT,
// five by default) a divider of four bits per step, a store read, a compare
// and a write for inserts, then a registered output; the back end finishes
// one transaction before taking the next. After reset the store is cleared
// word by word before the back end takes a transaction; size resets to 1024 words.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash
    import bfdh_pkg::*;
#(
    parameter int MAX_WORDS   = MAX_WORDS_DEF,
    parameter int PROBE_COUNT = PROBE_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [63:0]       key_digest,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              all_bits_set
);
    logic [SIZE_W-1:0] size_reg;
    logic              q_valid, q_ready;
    bfdh_item_t        q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_RESET;
        else if (cfg_we)
            size_reg <= cfg_wdata;
    end

    bfdh_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key_digest(key_digest),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    bfdh_back #(.MAX_WORDS(MAX_WORDS), .PROBE_COUNT(PROBE_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .size_in_words(size_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .all_bits_set(all_bits_set)
    );
endmodule
